// ===== hw/rtl/nfsp_pkg.sv =====
// Shared constants and types of the nearest free site placer.
package nfsp_pkg;

  // Default grid size.
  localparam int MaxRowsDef  = 32;
  localparam int MaxSitesDef = 256;

  // Field widths of the beats.
  localparam int CoordW     = 20;
  localparam int SpanW      = 9;
  localparam int SiteWidthW = 10;
  localparam int RowHeightW = 12;
  localparam int SitesCfgW  = 9;
  localparam int RowsCfgW   = 6;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 20;
  localparam int RowIdxW    = 5;
  localparam int SiteIdxW   = 8;
  localparam int PlacedW    = 22;
  localparam int MovedW     = 23;

  // Largest values of the coordinate registers and pitches.
  localparam int CoordMax     = 1048575;
  localparam int SiteWidthMax = 1023;
  localparam int RowHeightMax = 4095;

  // Register map of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgOriginX     = 3'd0,
    CfgOriginY     = 3'd1,
    CfgSiteWidth   = 3'd2,
    CfgRowHeight   = 3'd3,
    CfgSitesPerRow = 3'd4,
    CfgRowCount    = 3'd5
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    StPlaced = 2'd0,
    StFixed  = 2'd1,
    StNoSite = 2'd2
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    StateClear    = 9'b000000001,
    StateIdle     = 9'b000000010,
    StateSetup    = 9'b000000100,
    StateRowStart = 9'b000001000,
    StateScan     = 9'b000010000,
    StateDrain    = 9'b000100000,
    StateMarkRd   = 9'b001000000,
    StateMarkWr   = 9'b010000000,
    StateFinish   = 9'b100000000
  } state_e;

endpackage

// ===== hw/rtl/nearest_free_site_placer.sv =====
// Greedy nearest free site placer: occupancy bitmap, serial scan, run marking.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | want_x, want_y, span_sites, is_fixed
//   out     | output    | out_valid_o/out_ready_i| status, row_index, site_index, placed
//           |           |                        | x/y, moved_by
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index, cfg_value
//
// After reset the block sweeps the occupancy memory, one row per cycle, through all MAX_ROWS
// rows; in_ready_o stays low meanwhile while config beats are taken as usual.
// A placed cell is worked through the clamped row and site counts in use: one memory row
// read per row, then one site per cycle through the shared distance and compare unit. A
// cell with no free run skips the marking, one with no rows or sites skips the scan as
// well, and a fixed cell goes straight from its input beat to its result.
// One cell is in work at a time; a finished result sits in the output register, so the
// next input beat is taken while it waits. The block only stalls when a new result is
// ready and the previous one has not been taken yet.
module nearest_free_site_placer #(
  parameter int MAX_ROWS  = nfsp_pkg::MaxRowsDef,
  parameter int MAX_SITES = nfsp_pkg::MaxSitesDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [nfsp_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [nfsp_pkg::CfgDataW-1:0]         cfg_value_i,
  // cell requests
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [nfsp_pkg::CoordW-1:0]           want_x_i,
  input  logic [nfsp_pkg::CoordW-1:0]           want_y_i,
  input  logic [nfsp_pkg::SpanW-1:0]            span_sites_i,
  input  logic                                  is_fixed_i,
  // placement results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output nfsp_pkg::status_e                     status_o,
  output logic [nfsp_pkg::RowIdxW-1:0]          row_index_o,
  output logic [nfsp_pkg::SiteIdxW-1:0]         site_index_o,
  output logic [nfsp_pkg::PlacedW-1:0]          placed_x_o,
  output logic [nfsp_pkg::PlacedW-1:0]          placed_y_o,
  output logic [nfsp_pkg::MovedW-1:0]           moved_by_o
);
  import nfsp_pkg::*;

  // Index and count widths of the grid.
  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SIW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int SCW = $clog2(MAX_SITES + 1);
  // Run length and span compare width.
  localparam int CW  = (SCW > SpanW) ? SCW : SpanW;
  // Coordinate widths: origin plus the farthest site or row.
  localparam int XW  = $clog2(CoordMax + (MAX_SITES - 1) * SiteWidthMax + 1);
  localparam int YW  = $clog2(CoordMax + (MAX_ROWS - 1) * RowHeightMax + 1);
  localparam int DW  = ((XW > YW) ? XW : YW) + 1;
  // Offset from the last site of a run back to its first site.
  localparam int OffW = SpanW + SiteWidthW;

  // ---------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------
  logic [CoordW-1:0]     cfg_ox_q, cfg_oy_q;
  logic [SiteWidthW-1:0] cfg_sw_q;
  logic [RowHeightW-1:0] cfg_rh_q;
  logic [SitesCfgW-1:0]  cfg_spr_q;
  logic [RowsCfgW-1:0]   cfg_rc_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_ox_q  <= '0;
      cfg_oy_q  <= '0;
      cfg_sw_q  <= SiteWidthW'(1);
      cfg_rh_q  <= RowHeightW'(1);
      cfg_spr_q <= SitesCfgW'(256);
      cfg_rc_q  <= RowsCfgW'(32);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgOriginX:     cfg_ox_q  <= cfg_value_i[CoordW-1:0];
        CfgOriginY:     cfg_oy_q  <= cfg_value_i[CoordW-1:0];
        CfgSiteWidth:   cfg_sw_q  <= cfg_value_i[SiteWidthW-1:0];
        CfgRowHeight:   cfg_rh_q  <= cfg_value_i[RowHeightW-1:0];
        CfgSitesPerRow: cfg_spr_q <= cfg_value_i[SitesCfgW-1:0];
        CfgRowCount:    cfg_rc_q  <= cfg_value_i[RowsCfgW-1:0];
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

  // Geometry in use: clamp oversized settings to the built grid.
  logic [SCW-1:0] nsites;
  logic [RCW-1:0] nrows;
  assign nsites = (32'(cfg_spr_q) > MAX_SITES) ? SCW'(MAX_SITES) : SCW'(cfg_spr_q);
  assign nrows  = (32'(cfg_rc_q) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(cfg_rc_q);

  // ---------------------------------------------------------------------------------
  // Sequencer and working registers
  // ---------------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [CoordW-1:0] want_x_q, want_y_q;
  logic [SpanW-1:0]  span_q;
  logic              fixed_q;

  logic [RIW-1:0] r_q, clr_q;
  logic [SIW-1:0] s_q;
  logic [CW-1:0]  run_q;
  logic [XW-1:0]  x_q, off_q;
  logic [YW-1:0]  y_q, dy_q;

  // Occupancy memory, one row of sites per word.
  logic [MAX_SITES-1:0] occ_mem [MAX_ROWS];
  logic [MAX_SITES-1:0] row_q;
  logic                 mem_we, mem_re;
  logic [RIW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_SITES-1:0] mem_wdata;

  // Candidate stage, feeding the shared distance unit.
  logic           p_vld_q;
  logic [XW-1:0]  p_px_q;
  logic [SIW-1:0] p_start_q;
  logic [RIW-1:0] p_row_q;
  logic [YW-1:0]  p_py_q, p_dy_q;

  // Best run so far.
  logic           found_q;
  logic [DW-1:0]  best_d_q;
  logic [RIW-1:0] best_r_q;
  logic [SIW-1:0] best_s_q;
  logic [XW-1:0]  best_x_q;
  logic [YW-1:0]  best_y_q;

  logic out_valid_q;

  logic in_fire, out_free;
  assign in_ready_o = (state_q == StateIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Site scan: extend the free run, flag a run that fits the span.
  logic           bit_free, cand, last_site, last_row, last_clr;
  logic [CW-1:0]  run_n;
  logic [XW-1:0]  cand_px;
  logic [SIW-1:0] cand_start;

  assign bit_free   = !row_q[s_q];
  assign run_n      = bit_free ? (run_q + CW'(1)) : '0;
  assign cand       = bit_free && (run_n >= CW'(span_q));
  assign cand_px    = x_q - off_q;
  assign cand_start = SIW'(CW'(s_q) + CW'(1) - CW'(span_q));
  assign last_site  = (SCW'(s_q) == (nsites - SCW'(1)));
  assign last_row   = (RCW'(r_q) == (nrows - RCW'(1)));
  assign last_clr   = (32'(clr_q) == (MAX_ROWS - 1));

  // Shared distance and compare unit: one candidate per cycle.
  logic [XW-1:0] dx;
  logic [DW-1:0] cand_dist;
  logic          better;

  assign dx        = (p_px_q >= XW'(want_x_q)) ? (p_px_q - XW'(want_x_q))
                                               : (XW'(want_x_q) - p_px_q);
  assign cand_dist = DW'(dx) + DW'(p_dy_q);
  assign better    = p_vld_q && (!found_q || (cand_dist < best_d_q));

  // Offset of the run start: (span - 1) * site width, formed once per cell.
  logic [OffW-1:0] off_prod;
  assign off_prod = OffW'(span_q - SpanW'(1)) * OffW'(cfg_sw_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateClear:    if (last_clr) state_d = StateIdle;
      StateIdle: begin
        if (in_fire) state_d = is_fixed_i ? StateFinish : StateSetup;
      end
      StateSetup: begin
        state_d = ((nrows == '0) || (nsites == '0)) ? StateDrain : StateRowStart;
      end
      StateRowStart: state_d = StateScan;
      StateScan: begin
        if (last_site) state_d = last_row ? StateDrain : StateRowStart;
      end
      StateDrain:    state_d = found_q || better ? StateMarkRd : StateFinish;
      StateMarkRd:   state_d = StateMarkWr;
      StateMarkWr:   state_d = StateFinish;
      StateFinish:   if (out_free) state_d = StateIdle;
      default:       state_d = StateClear;
    endcase
  end

  // Run mask for marking: sites from best_s_q on, span_q of them.
  logic [MAX_SITES-1:0] run_mask;
  logic [CW-1:0]        run_end;
  assign run_end = CW'(best_s_q) + CW'(span_q);
  always_comb begin
    for (int i = 0; i < MAX_SITES; i++) begin
      run_mask[i] = (CW'(i) >= CW'(best_s_q)) && (CW'(i) < run_end);
    end
  end

  // Memory port control: clear sweep, row reads, marking write.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = r_q;
    priority if (state_q == StateClear) begin
      mem_we = 1'b1;
    end else if (state_q == StateMarkWr) begin
      mem_we    = 1'b1;
      mem_waddr = best_r_q;
      mem_wdata = row_q | run_mask;
    end else if (state_q == StateRowStart) begin
      mem_re = 1'b1;
    end else if (state_q == StateMarkRd) begin
      mem_re    = 1'b1;
      mem_raddr = best_r_q;
    end else begin
      mem_re = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
    if (mem_re) row_q <= occ_mem[mem_raddr];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateClear;
      clr_q       <= '0;
      p_vld_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StateClear) clr_q <= clr_q + RIW'(1);
      p_vld_q <= (state_q == StateScan) && cand;
      if (in_fire) begin
        found_q <= 1'b0;
      end else if (better) begin
        found_q <= 1'b1;
      end
      if ((state_q == StateFinish) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      want_x_q <= want_x_i;
      want_y_q <= want_y_i;
      span_q   <= (span_sites_i == '0) ? SpanW'(1) : span_sites_i;
      fixed_q  <= is_fixed_i;
    end
    if (state_q == StateSetup) begin
      off_q <= XW'(off_prod);
      r_q   <= '0;
      y_q   <= YW'(cfg_oy_q);
    end
    if (state_q == StateRowStart) begin
      dy_q  <= (y_q >= YW'(want_y_q)) ? (y_q - YW'(want_y_q)) : (YW'(want_y_q) - y_q);
      s_q   <= '0;
      run_q <= '0;
      x_q   <= XW'(cfg_ox_q);
    end
    if (state_q == StateScan) begin
      run_q <= run_n;
      x_q   <= x_q + XW'(cfg_sw_q);
      s_q   <= s_q + SIW'(1);
      if (last_site) begin
        r_q <= r_q + RIW'(1);
        y_q <= y_q + YW'(cfg_rh_q);
      end
    end
    // Carry the candidate to the distance unit.
    p_px_q    <= cand_px;
    p_start_q <= cand_start;
    p_row_q   <= r_q;
    p_py_q    <= y_q;
    p_dy_q    <= dy_q;
    // Keep the first strictly nearer run.
    if (better) begin
      best_d_q <= cand_dist;
      best_r_q <= p_row_q;
      best_s_q <= p_start_q;
      best_x_q <= p_px_q;
      best_y_q <= p_py_q;
    end
    // Load the result register.
    if ((state_q == StateFinish) && out_free) begin
      if (fixed_q) begin
        status_o <= StFixed;
      end else if (found_q) begin
        status_o <= StPlaced;
      end else begin
        status_o <= StNoSite;
      end
      row_index_o  <= (found_q && !fixed_q) ? RowIdxW'(best_r_q) : '0;
      site_index_o <= (found_q && !fixed_q) ? SiteIdxW'(best_s_q) : '0;
      placed_x_o   <= (found_q && !fixed_q) ? PlacedW'(best_x_q) : '0;
      placed_y_o   <= (found_q && !fixed_q) ? PlacedW'(best_y_q) : '0;
      moved_by_o   <= (found_q && !fixed_q) ? MovedW'(best_d_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The chosen run lies wholly inside the row.
  a_run_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && (state_q == StateMarkWr)) |-> (run_end <= CW'(nsites)))
    else $error("chosen run crosses the row end");

  // Only a found run is ever marked.
  a_mark_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateMarkWr) |-> found_q)
    else $error("marking without a found run");

  // The scan stays inside the grid in use.
  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StateScan) |-> ((SCW'(s_q) < nsites) && (RCW'(r_q) < nrows)))
    else $error("scan left the grid");

  // A new result only comes out of the finish step.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == StateFinish))
    else $error("result raised outside the finish step");

  // Candidates only enter the distance unit from the scan.
  a_cand_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> $past(state_q == StateScan))
    else $error("candidate outside the scan");
`endif

endmodule
